// ----- rtl/core/pendulum_rk4_step_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the pendulum RK4 step block
// Shared property forms for the latency checks at the top level.
// ----------------------------------------------------------------------------
`ifndef PENDULUM_RK4_STEP_ASSERT_SVH
`define PENDULUM_RK4_STEP_ASSERT_SVH

// Check that cond holds after trig, delayed by n.
`define PRK_ASSERT_AFTER(lbl, clk, rst_n, trig, n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> ##n (cond)) \
    else $error("pendulum_rk4_step: expected event missing after fixed delay");

// Check that whenever cond holds, prior held at the delay n before it.
`define PRK_ASSERT_PAST(lbl, clk, rst_n, cond, n, prior) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> $past(prior, n)) \
    else $error("pendulum_rk4_step: event without matching cause");

`endif

// ----- rtl/core/prk_pkg.sv -----
// ----------------------------------------------------------------------------
// prk_pkg
// Widths, constants, item type and helper functions of the RK4 pendulum step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package prk_pkg;

  // Fixed point format and field widths
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int COEF_W    = 31;
  localparam int STEP_W    = 16;
  localparam int CFG_IDX_W = 2;

  // Weighted stage sum k1 + 2*k2 + 2*k3 + k4 of 32-bit values
  localparam int SUM_W  = 35;
  // Step times stage value, step times weighted sum
  localparam int PH_W   = STEP_W + 1 + DATA_W;
  localparam int PROD_W = STEP_W + 1 + SUM_W;
  // Product divided by 2^(FRAC_BITS+1), before the divide by three
  localparam int Q_W    = PROD_W - FRAC_BITS - 1;
  // Biased dividend, padded to whole nibbles
  localparam int U_W    = 4 * ((Q_W + 4) / 4);
  localparam int NIB    = U_W / 4;
  localparam int NIB_LO = NIB / 2;
  // Wide signed width for sums ahead of saturation
  localparam int SAT_W  = 65;

  // Cycles from accepted item to result strobe
  localparam int LATENCY = 20;

  localparam logic [STEP_W-1:0] STEP_RESET = 16'd1092;

  // Bias that makes the dividend non-negative; a multiple of three
  localparam logic [U_W-1:0] DIV_BIAS = U_W'(3) << (Q_W - 2);
  // Bias divided by three, removed after the divide
  localparam logic signed [SAT_W-1:0] DIV_OFF = SAT_W'(1) << (Q_W - 2);

  localparam logic signed [SAT_W-1:0] S32_MAX_W = SAT_W'(32'sh7fffffff);
  localparam logic signed [SAT_W-1:0] S32_MIN_W = SAT_W'(32'sh80000000);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DAMPING   = 2'd0,
    REG_STIFFNESS = 2'd1,
    REG_STEP      = 2'd2
  } prk_reg_e;

  // One item on its way through the integrator stages
  typedef struct packed {
    logic signed [DATA_W-1:0] x;   // input angle
    logic signed [DATA_W-1:0] v;   // input velocity
    logic signed [DATA_W-1:0] ex;  // angle at which the next acceleration is taken
    logic signed [DATA_W-1:0] kx;  // latest angle slope (velocity at that point)
    logic signed [DATA_W-1:0] kv;  // latest velocity slope (acceleration)
    logic signed [SUM_W-1:0]  sx;  // weighted angle slopes so far
    logic signed [SUM_W-1:0]  sv;  // weighted velocity slopes so far
  } prk_item_t;

  // One radix-16 digit step of a divide by three
  typedef struct packed {
    logic [3:0] q;
    logic [1:0] r;
  } prk_div3_t;

  // Clamp a wide signed value to the signed 32-bit range
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] a);
    logic signed [DATA_W-1:0] res;
    if (a > S32_MAX_W) begin
      res = 32'sh7fffffff;
    end else if (a < S32_MIN_W) begin
      res = 32'sh80000000;
    end else begin
      res = a[DATA_W-1:0];
    end
    return res;
  endfunction

  // Divide {r, nib} (below 48) by three: q = (n * 43) >> 7 is exact there
  function automatic prk_div3_t div3_step(input logic [1:0] r, input logic [3:0] nib);
    logic [5:0]  n;
    logic [11:0] m;
    prk_div3_t   res;
    n     = {r, nib};
    m     = {6'd0, n} * 12'd43;
    res.q = m[10:7];
    res.r = 2'(n - ({2'b00, res.q} + {1'b0, res.q, 1'b0}));
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/pendulum_rk4_step.sv -----
// Path: an item accepted at a clock edge is strobed on done_o once it has passed
//   four acceleration units, three step units and six output stages, all
//   registered.
// Throughput: one item per cycle; busy stays low and start is taken at any edge.
// Results cannot be held off; each lasts exactly one cycle.
// Reset: rst_ni clears all valid bits and loads damping 0, stiffness 0, step 1092.
// ----------------------------------------------------------------------------
// pendulum_rk4_step
// One classic RK4 step of a linearised damped pendulum in signed fixed point.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "pendulum_rk4_step_assert.svh"

module pendulum_rk4_step import prk_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // Configuration writes
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [COEF_W-1:0]    cfg_wdata_i,
  // Item input
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [DATA_W-1:0]    angle_in_i,
  input  wire logic [DATA_W-1:0]    velocity_in_i,
  // Result output
  output logic                      done_o,
  output logic [DATA_W-1:0]         angle_out_o,
  output logic [DATA_W-1:0]         velocity_out_o
);

  logic [COEF_W-1:0] damping_q, stiffness_q;
  logic [STEP_W-1:0] step_q;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      damping_q   <= '0;
      stiffness_q <= '0;
      step_q      <= STEP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DAMPING:   damping_q   <= cfg_wdata_i;
        REG_STIFFNESS: stiffness_q <= cfg_wdata_i;
        REG_STEP:      step_q      <= cfg_wdata_i[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Accept an item whenever start is high
  logic      in_valid;
  prk_item_t in_item;

  assign busy     = 1'b0;
  assign in_valid = start & ~busy;

  always_comb begin
    in_item    = '0;
    in_item.x  = $signed(angle_in_i);
    in_item.v  = $signed(velocity_in_i);
    in_item.ex = $signed(angle_in_i);
    in_item.kx = $signed(velocity_in_i);
  end

  // Stage chain: accel k1, step, accel k2, step, accel k3, step, accel k4
  logic      a_valid [4];
  prk_item_t a_item  [4];
  logic      s_valid [3];
  prk_item_t s_item  [3];

  prk_accel u_accel1 (
    .clk_i, .rst_ni,
    .damping_i(damping_q), .stiffness_i(stiffness_q),
    .valid_i(in_valid), .item_i(in_item),
    .valid_o(a_valid[0]), .item_o(a_item[0])
  );

  prk_advance u_adv2 (
    .clk_i, .rst_ni,
    .step_i(step_q), .half_i(1'b1), .double_i(1'b0),
    .valid_i(a_valid[0]), .item_i(a_item[0]),
    .valid_o(s_valid[0]), .item_o(s_item[0])
  );

  prk_accel u_accel2 (
    .clk_i, .rst_ni,
    .damping_i(damping_q), .stiffness_i(stiffness_q),
    .valid_i(s_valid[0]), .item_i(s_item[0]),
    .valid_o(a_valid[1]), .item_o(a_item[1])
  );

  prk_advance u_adv3 (
    .clk_i, .rst_ni,
    .step_i(step_q), .half_i(1'b1), .double_i(1'b1),
    .valid_i(a_valid[1]), .item_i(a_item[1]),
    .valid_o(s_valid[1]), .item_o(s_item[1])
  );

  prk_accel u_accel3 (
    .clk_i, .rst_ni,
    .damping_i(damping_q), .stiffness_i(stiffness_q),
    .valid_i(s_valid[1]), .item_i(s_item[1]),
    .valid_o(a_valid[2]), .item_o(a_item[2])
  );

  prk_advance u_adv4 (
    .clk_i, .rst_ni,
    .step_i(step_q), .half_i(1'b0), .double_i(1'b1),
    .valid_i(a_valid[2]), .item_i(a_item[2]),
    .valid_o(s_valid[2]), .item_o(s_item[2])
  );

  prk_accel u_accel4 (
    .clk_i, .rst_ni,
    .damping_i(damping_q), .stiffness_i(stiffness_q),
    .valid_i(s_valid[2]), .item_i(s_item[2]),
    .valid_o(a_valid[3]), .item_o(a_item[3])
  );

  // Combine the slopes into the result
  prk_finish u_finish (
    .clk_i, .rst_ni,
    .step_i(step_q),
    .valid_i(a_valid[3]), .item_i(a_item[3]),
    .valid_o(done_o),
    .angle_o(angle_out_o),
    .velocity_o(velocity_out_o)
  );

  // Every accepted item comes out after the fixed latency, and nothing else does
  `PRK_ASSERT_AFTER(a_done_after_start, clk_i, rst_ni, start, LATENCY, done_o)
  `PRK_ASSERT_PAST(a_done_has_start, clk_i, rst_ni, done_o, LATENCY, start)

endmodule

`default_nettype wire

// ----- rtl/core/prk_accel.sv -----
// ----------------------------------------------------------------------------
// prk_accel
// Two-stage acceleration unit: a = sat(-damping*v - stiffness*x).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module prk_accel import prk_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [COEF_W-1:0] damping_i,
  input  wire logic [COEF_W-1:0] stiffness_i,
  input  wire logic              valid_i,
  input  wire prk_item_t         item_i,
  output logic                   valid_o,
  output prk_item_t              item_o
);

  logic                        valid1_q, valid2_q;
  prk_item_t                   item1_q, item2_q, item2_d;
  logic signed [2*DATA_W-1:0]  dv_q, sx_q;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
    end
  end

  // Form both coefficient products
  always_ff @(posedge clk_i) begin
    item1_q <= item_i;
    dv_q    <= (2 * DATA_W)'($signed({1'b0, damping_i})) * (2 * DATA_W)'(item_i.kx);
    sx_q    <= (2 * DATA_W)'($signed({1'b0, stiffness_i})) * (2 * DATA_W)'(item_i.ex);
  end

  // Scale, negate and clamp the acceleration
  always_comb begin
    item2_d    = item1_q;
    item2_d.kv = sat32(-SAT_W'(dv_q >>> FRAC_BITS) - SAT_W'(sx_q >>> FRAC_BITS));
  end

  always_ff @(posedge clk_i) begin
    item2_q <= item2_d;
  end

  assign valid_o = valid2_q;
  assign item_o  = item2_q;

endmodule

`default_nettype wire

// ----- rtl/core/prk_advance.sv -----
// ----------------------------------------------------------------------------
// prk_advance
// Two-stage step to the next evaluation point; folds the last slopes into
// the weighted sums.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module prk_advance import prk_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [STEP_W-1:0] step_i,
  input  wire logic              half_i,    // step by h/2 instead of h
  input  wire logic              double_i,  // slopes count twice in the sums
  input  wire logic              valid_i,
  input  wire prk_item_t         item_i,
  output logic                   valid_o,
  output prk_item_t              item_o
);

  logic                    valid1_q, valid2_q;
  prk_item_t               item1_q, item2_q, item2_d;
  logic signed [PH_W-1:0]  phv_q, phx_q;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
    end
  end

  // Multiply both slopes by the step
  always_ff @(posedge clk_i) begin
    item1_q <= item_i;
    phv_q   <= PH_W'($signed({1'b0, step_i})) * PH_W'(item_i.kv);
    phx_q   <= PH_W'($signed({1'b0, step_i})) * PH_W'(item_i.kx);
  end

  // Move to the next point and accumulate the weighted slopes
  always_comb begin
    logic signed [PH_W-1:0]  shv, shx;
    logic signed [SUM_W-1:0] wx, wv;
    shv = half_i ? (phv_q >>> (FRAC_BITS + 1)) : (phv_q >>> FRAC_BITS);
    shx = half_i ? (phx_q >>> (FRAC_BITS + 1)) : (phx_q >>> FRAC_BITS);
    wx  = double_i ? (SUM_W'(item1_q.kx) <<< 1) : SUM_W'(item1_q.kx);
    wv  = double_i ? (SUM_W'(item1_q.kv) <<< 1) : SUM_W'(item1_q.kv);
    item2_d    = item1_q;
    item2_d.sx = item1_q.sx + wx;
    item2_d.sv = item1_q.sv + wv;
    item2_d.kx = sat32(SAT_W'(item1_q.v) + SAT_W'(shv));
    item2_d.ex = sat32(SAT_W'(item1_q.x) + SAT_W'(shx));
  end

  always_ff @(posedge clk_i) begin
    item2_q <= item2_d;
  end

  assign valid_o = valid2_q;
  assign item_o  = item2_q;

endmodule

`default_nettype wire

// ----- rtl/core/prk_finish.sv -----
// ----------------------------------------------------------------------------
// prk_finish
// Six-stage output path: x + floor(h * sum / (6 * 2^FRAC_BITS)), clamped,
// for angle (lane 0) and velocity (lane 1).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module prk_finish import prk_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [STEP_W-1:0] step_i,
  input  wire logic              valid_i,
  input  wire prk_item_t         item_i,
  output logic                   valid_o,
  output logic [DATA_W-1:0]      angle_o,
  output logic [DATA_W-1:0]      velocity_o
);

  localparam int NSTG = 6;

  logic [NSTG-1:0] valid_q;

  // Base values carried to the final add, one entry per stage before it
  logic signed [DATA_W-1:0] base_q [NSTG-1][2];

  logic signed [SUM_W-1:0]  sum_q  [2];
  logic signed [PROD_W-1:0] prod_q [2];
  logic [U_W-1:0]           u_q    [2];
  logic [U_W-1:0]           qh_q   [2];
  logic [1:0]               rh_q   [2];
  logic [U_W-1:0]           quo_q  [2];
  logic [U_W-1:0]           qh_d   [2];
  logic [1:0]               rh_d   [2];
  logic [U_W-1:0]           quo_d  [2];
  logic signed [DATA_W-1:0] res_q  [2];

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[NSTG-2:0], valid_i};
    end
  end

  // Carry the base values down the pipe
  always_ff @(posedge clk_i) begin
    base_q[0][0] <= item_i.x;
    base_q[0][1] <= item_i.v;
    for (int s = 1; s < NSTG - 1; s++) begin
      base_q[s] <= base_q[s-1];
    end
  end

  // Close the weighted sums, multiply by the step, bias the dividend
  always_ff @(posedge clk_i) begin
    sum_q[0] <= item_i.sx + SUM_W'(item_i.kx);
    sum_q[1] <= item_i.sv + SUM_W'(item_i.kv);
    for (int l = 0; l < 2; l++) begin
      prod_q[l] <= PROD_W'($signed({1'b0, step_i})) * PROD_W'(sum_q[l]);
      u_q[l]    <= U_W'(Q_W'(prod_q[l] >>> (FRAC_BITS + 1))) + DIV_BIAS;
    end
  end

  // Divide by three, upper digits
  always_comb begin
    prk_div3_t st;
    logic [1:0] rem;
    for (int l = 0; l < 2; l++) begin
      rem     = 2'd0;
      qh_d[l] = u_q[l];
      for (int d = NIB - 1; d >= NIB_LO; d--) begin
        st               = div3_step(rem, u_q[l][4*d +: 4]);
        qh_d[l][4*d +: 4] = st.q;
        rem              = st.r;
      end
      rh_d[l] = rem;
    end
  end

  always_ff @(posedge clk_i) begin
    qh_q <= qh_d;
    rh_q <= rh_d;
  end

  // Divide by three, lower digits
  always_comb begin
    prk_div3_t st;
    logic [1:0] rem;
    for (int l = 0; l < 2; l++) begin
      rem      = rh_q[l];
      quo_d[l] = qh_q[l];
      for (int d = NIB_LO - 1; d >= 0; d--) begin
        st                 = div3_step(rem, qh_q[l][4*d +: 4]);
        quo_d[l][4*d +: 4] = st.q;
        rem                = st.r;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
  end

  // Remove the bias, add to the base value and clamp
  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 2; l++) begin
      res_q[l] <= sat32(SAT_W'(base_q[NSTG-2][l]) + SAT_W'($signed({1'b0, quo_q[l]}))
                        - DIV_OFF);
    end
  end

  assign valid_o    = valid_q[NSTG-1];
  assign angle_o    = res_q[0];
  assign velocity_o = res_q[1];

endmodule

`default_nettype wire

// ----- tb/pendulum_rk4_step_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pendulum_rk4_step_tb
// Self-checking bench for the fixed-point RK4 pendulum step. A shadow
// integrator predicts every result from the accepted item and the current
// coefficients. Directed extremes come first, then random phases with
// changing coefficients and random start gaps.
// ----------------------------------------------------------------------------

module pendulum_rk4_step_tb;
  import prk_pkg::*;

  localparam logic [CFG_IDX_W-1:0]    REG_NONE = 2'd3;  // unmapped index
  localparam logic signed [DATA_W-1:0] Q_MAX   = 32'sh7fffffff;
  localparam logic signed [DATA_W-1:0] Q_MIN   = 32'sh80000000;
  localparam logic [COEF_W-1:0]       COEF_MAX = 31'h7fffffff;
  localparam longint                  S32_HI   = 64'sd2147483647;
  localparam longint                  S32_LO   = -64'sd2147483648;

  typedef struct packed {
    logic signed [DATA_W-1:0] angle;
    logic signed [DATA_W-1:0] velocity;
  } state_pair_t;

  // Shadow integrator with its own copy of the coefficients
  class pendulum_board;
    logic [COEF_W-1:0] damping;
    logic [COEF_W-1:0] stiffness;
    logic [STEP_W-1:0] step;
    state_pair_t       pending_states[$];
    int unsigned       faults;
    int unsigned       checked;

    function new();
      damping   = '0;
      stiffness = '0;
      step      = STEP_RESET;
      faults    = 0;
      checked   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
      case (idx)
        REG_DAMPING: begin
          damping = data;
        end
        REG_STIFFNESS: begin
          stiffness = data;
        end
        REG_STEP: begin
          step = data[STEP_W-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    function longint clamp32(longint a);
      if (a > S32_HI) return S32_HI;
      if (a < S32_LO) return S32_LO;
      return a;
    endfunction

    // Exact product, floor shift
    function longint scaled(longint a, longint b, int unsigned sh);
      return (a * b) >>> sh;
    endfunction

    function longint floor_div(longint p, longint d);
      longint q;
      q = p / d;
      if (p < 0 && (p % d) != 0) q = q - 1;
      return q;
    endfunction

    function longint accel(longint x, longint v);
      longint d;
      longint s;
      d = longint'(damping);
      s = longint'(stiffness);
      return clamp32(-scaled(d, v, FRAC_BITS) - scaled(s, x, FRAC_BITS));
    endfunction

    function state_pair_t rk4_advance(logic signed [DATA_W-1:0] ang,
                                      logic signed [DATA_W-1:0] vel);
      longint x, v, h, den;
      longint kx1, kx2, kx3, kx4;
      longint kv1, kv2, kv3, kv4;
      longint sx, sv;
      state_pair_t res;
      x = longint'(ang);
      v = longint'(vel);
      h = longint'(step);
      // Half steps shift one extra bit
      kx1 = v;
      kv1 = accel(x, v);
      kx2 = clamp32(v + scaled(h, kv1, FRAC_BITS + 1));
      kv2 = accel(clamp32(x + scaled(h, kx1, FRAC_BITS + 1)), kx2);
      kx3 = clamp32(v + scaled(h, kv2, FRAC_BITS + 1));
      kv3 = accel(clamp32(x + scaled(h, kx2, FRAC_BITS + 1)), kx3);
      kx4 = clamp32(v + scaled(h, kv3, FRAC_BITS));
      kv4 = accel(clamp32(x + scaled(h, kx3, FRAC_BITS)), kx4);
      // Weighted sums stay exact until the final divide
      sx  = kx1 + 2 * kx2 + 2 * kx3 + kx4;
      sv  = kv1 + 2 * kv2 + 2 * kv3 + kv4;
      den = 64'sd6 <<< FRAC_BITS;
      res.angle    = DATA_W'(clamp32(x + floor_div(h * sx, den)));
      res.velocity = DATA_W'(clamp32(v + floor_div(h * sv, den)));
      return res;
    endfunction

    function void note_input(logic signed [DATA_W-1:0] ang,
                             logic signed [DATA_W-1:0] vel);
      pending_states.push_back(rk4_advance(ang, vel));
    endfunction

    function void check_result(logic signed [DATA_W-1:0] ang,
                               logic signed [DATA_W-1:0] vel);
      state_pair_t want;
      if (pending_states.size() == 0) begin
        faults++;
        $error("result strobe with no item in flight");
        return;
      end
      want = pending_states.pop_front();
      checked++;
      if (ang !== want.angle) begin
        faults++;
        $error("angle_out: expected %0d, actual %0d", $signed(want.angle), ang);
      end
      if (vel !== want.velocity) begin
        faults++;
        $error("velocity_out: expected %0d, actual %0d", $signed(want.velocity), vel);
      end
    endfunction

    function int pending();
      return pending_states.size();
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [COEF_W-1:0]    cfg_wdata_i;
  logic                 start;
  logic                 busy;
  logic [DATA_W-1:0]    angle_in_i;
  logic [DATA_W-1:0]    velocity_in_i;
  logic                 done_o;
  logic [DATA_W-1:0]    angle_out_o;
  logic [DATA_W-1:0]    velocity_out_o;

  pendulum_board board;
  bit            no_idle;
  int unsigned   items_sent;
  int unsigned   settings_used;

  pendulum_rk4_step dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .start          (start),
    .busy           (busy),
    .angle_in_i     (angle_in_i),
    .velocity_in_i  (velocity_in_i),
    .done_o         (done_o),
    .angle_out_o    (angle_out_o),
    .velocity_out_o (velocity_out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Check every strobed result against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      board.check_result(angle_out_o, velocity_out_o);
    end
  end

  // Mix of full-range, small and boundary values
  function automatic logic signed [DATA_W-1:0] rand_field();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return $urandom;
    if (pick < 8) return $urandom_range(0, 1 << 19) - (1 << 18);
    case ($urandom_range(0, 4))
      0:       return Q_MAX;
      1:       return Q_MIN;
      2:       return '0;
      3:       return '1;
      default: return 32'sd1;
    endcase
  endfunction

  // Drop start through a random gap, then offer one item until taken
  task automatic send_item(logic signed [DATA_W-1:0] ang, logic signed [DATA_W-1:0] vel);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      start         <= 1'b0;
      angle_in_i    <= $urandom;
      velocity_in_i <= $urandom;
      repeat (gap) @(negedge clk_i);
    end
    start         <= 1'b1;
    angle_in_i    <= ang;
    velocity_in_i <= vel;
    do @(posedge clk_i); while (busy === 1'b1);
    board.note_input(ang, vel);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Drop start and wait for every item in flight to come back
  task automatic settle();
    start <= 1'b0;
    do @(negedge clk_i); while (board.pending() != 0);
  endtask

  // Leaves the write enable high; the caller drops it
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    board.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  task automatic apply_settings(logic [COEF_W-1:0] damp, logic [COEF_W-1:0] stiff,
                                logic [COEF_W-1:0] step_word);
    write_reg(REG_DAMPING, damp);
    write_reg(REG_STIFFNESS, stiff);
    write_reg(REG_STEP, step_word);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  initial begin
    logic [COEF_W-1:0] d, s, h;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    start         = 1'b0;
    angle_in_i    = '0;
    velocity_in_i = '0;
    board         = new();
    no_idle       = 1'b0;
    items_sent    = 0;
    settings_used = 1;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset coefficients: free motion
    send_item('0, '0);
    send_item(Q_MAX, Q_MAX);
    send_item(Q_MIN, Q_MIN);
    send_item(Q_MAX, Q_MIN);
    send_item(32'sd1, '1);
    settle();

    // Largest coefficients and step: saturate every stage
    apply_settings(COEF_MAX, COEF_MAX, 31'h0000ffff);
    send_item(Q_MAX, Q_MIN);
    send_item(Q_MIN, Q_MAX);
    send_item('1, '1);
    send_item(32'sd65536, '0);
    settle();

    // Plausible pendulum: damping 0.5, stiffness 9.8, step 1/60
    apply_settings(31'd32768, 31'd642252, 31'd1092);
    send_item(32'sd65536, '0);
    send_item(-32'sd32768, 32'sd131072);
    send_item('0, 32'sd65536);
    settle();

    // Zero step through a word with high bits set: output equals input
    apply_settings(31'd65536, 31'd65536, 31'h7fff0000);
    send_item(Q_MAX, Q_MAX);
    send_item(Q_MIN, '1);
    settle();

    // Unmapped index must leave the coefficients alone
    write_reg(REG_NONE, COEF_MAX);
    cfg_we_i <= 1'b0;
    send_item(32'sd12345, -32'sd6789);
    settle();

    // Random phases, each with fresh coefficients
    for (int ph = 0; ph < 10; ph++) begin
      case ($urandom_range(0, 3))
        0: begin
          d = COEF_W'($urandom_range(0, 1 << 17));
          s = COEF_W'($urandom_range(0, 1 << 21));
          h = COEF_W'($urandom_range(0, 4096));
        end
        1: begin
          d = COEF_W'($urandom);
          s = COEF_W'($urandom);
          h = COEF_W'($urandom);
        end
        2: begin
          d = $urandom_range(0, 1) ? COEF_MAX : '0;
          s = $urandom_range(0, 1) ? COEF_MAX : '0;
          h = $urandom_range(0, 1) ? 31'h0000ffff : '0;
        end
        default: begin
          d = COEF_W'($urandom_range(0, 1 << 24));
          s = COEF_W'($urandom_range(0, 1 << 24));
          h = COEF_W'($urandom);
        end
      endcase
      apply_settings(d, s, h);
      no_idle = ($urandom_range(0, 3) == 0);
      repeat (75) begin
        if ($urandom_range(0, 99) == 0) settle();
        send_item(rand_field(), rand_field());
      end
      settle();
    end

    // Drain and watch for stray strobes
    repeat (LATENCY + 4) @(posedge clk_i);
    $display("Sent %0d items over %0d coefficient settings; %0d results compared.",
             items_sent, settings_used, board.checked);
    if (board.faults == 0 && board.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #5000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
